/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define CHCB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define CHCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/chcb_pkg.sv */
// ----------------------------------------------------------------------------
// chcb_pkg
// shared widths, codes and types of the canonical huffman code builder
// ----------------------------------------------------------------------------
package chcb_pkg;

   localparam int SYM_W           = 9;
   localparam int LEN_W           = 4;
   localparam int CODE_W          = 15;
   localparam int OP_W            = 2;
   localparam int STATUS_W        = 2;
   localparam int HIST_DEPTH      = 16;
   localparam int NUM_SYMBOLS_DEF = 288;
   localparam int MAX_LEN_DEF     = 15;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD       = 2'd1,
      ST_NOT_BUILT = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_HIST   = 6'b000100,
      S_KRAFT  = 6'b001000,
      S_ASSIGN = 6'b010000,
      S_DONE   = 6'b100000
   } bld_state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic bad;
      logic len_rd;
      logic len_wr;
      logic code_wr;
   } bld_ctrl_type;

endpackage

/* rtl/chcb_ram.sv */
// ----------------------------------------------------------------------------
// chcb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module chcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/chcb_builder.sv */
// ----------------------------------------------------------------------------
// chcb_builder
// build sequencer: clear sweep, length histogram, kraft check, code assignment
// ----------------------------------------------------------------------------
module chcb_builder import chcb_pkg::*; #(
   parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
   parameter int MAX_LEN     = MAX_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output bld_ctrl_type                   ctrl,
   output logic [$clog2(NUM_SYMBOLS)-1:0] len_addr,
   input  logic [LEN_W-1:0]               len_rdata,
   output logic [$clog2(NUM_SYMBOLS)-1:0] code_wr_addr,
   output logic [CODE_W-1:0]              code_wr_data
);

   localparam int AW = $clog2(NUM_SYMBOLS);
   localparam int CW = $clog2(NUM_SYMBOLS + 1);
   localparam int KW = CW + CODE_W;
   localparam logic [CW-1:0]    LAST     = CW'(NUM_SYMBOLS);
   localparam logic [CW-1:0]    LAST_IDX = CW'(NUM_SYMBOLS - 1);
   localparam logic [LEN_W-1:0] K_LAST   = LEN_W'(HIST_DEPTH - 1);
   localparam logic [KW-1:0]    KRAFT_FULL = KW'(1) << CODE_W;

   bld_state_type     state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     waddr_ff, waddr_in;
   logic [CW-1:0]     counts_ff [HIST_DEPTH];
   logic [CW-1:0]     counts_in [HIST_DEPTH];
   logic [CODE_W-1:0] next_ff [HIST_DEPTH];
   logic [CODE_W-1:0] next_in [HIST_DEPTH];
   logic [KW-1:0]     kraft_ff, kraft_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic              bad_ff, bad_in;
   logic              err;
   logic [CODE_W-1:0] next_sum;

   assign err      = bad_ff | (kraft_ff != KRAFT_FULL);
   assign next_sum = next_ff[k_ff] + CODE_W'(counts_ff[k_ff]);
   assign len_addr = cnt_ff[AW-1:0];
   assign code_wr_addr = waddr_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = 1'b0;
      waddr_in  = waddr_ff;
      counts_in = counts_ff;
      next_in   = next_ff;
      kraft_in  = kraft_ff;
      k_in      = k_ff;
      bad_in    = bad_ff;
      code_wr_data = '0;
      ctrl      = '0;
      ctrl.busy = (state_ff != S_IDLE);
      ctrl.bad  = err;
      case (state_ff)
         S_CLEAR: begin
            ctrl.len_wr = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in = S_HIST;
               cnt_in   = '0;
               bad_in   = 1'b0;
               kraft_in = '0;
               next_in[1] = '0;
               for (int i = 0; i < HIST_DEPTH; i++) begin
                  counts_in[i] = '0;
               end
            end
         end
         S_HIST: begin
            // read data is registered, so it arrives in the cycle after its address
            if (pend_ff) begin
               if (32'(len_rdata) > MAX_LEN) begin
                  bad_in = 1'b1;
               end
               if (len_rdata != '0) begin
                  counts_in[len_rdata] = counts_ff[len_rdata] + CW'(1);
               end
            end
            if (cnt_ff != LAST) begin
               ctrl.len_rd = 1'b1;
               pend_in     = 1'b1;
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               state_in = S_KRAFT;
               k_in     = LEN_W'(1);
            end
         end
         S_KRAFT: begin
            // horner form of the scaled kraft sum
            kraft_in = {kraft_ff[KW-2:0], 1'b0} + KW'(counts_ff[k_ff]);
            if (k_ff != K_LAST) begin
               next_in[k_ff + LEN_W'(1)] = {next_sum[CODE_W-2:0], 1'b0};
               k_in = k_ff + LEN_W'(1);
            end else begin
               state_in = S_ASSIGN;
               cnt_in   = '0;
            end
         end
         S_ASSIGN: begin
            if (pend_ff) begin
               ctrl.code_wr = 1'b1;
               if (!err && len_rdata != '0) begin
                  code_wr_data        = next_ff[len_rdata];
                  next_in[len_rdata]  = next_ff[len_rdata] + CODE_W'(1);
               end
            end
            if (cnt_ff != LAST) begin
               ctrl.len_rd = 1'b1;
               pend_in     = 1'b1;
               waddr_in    = cnt_ff[AW-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            ctrl.done = 1'b1;
            state_in  = S_IDLE;
            cnt_in    = '0;
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      waddr_ff  <= waddr_in;
      counts_ff <= counts_in;
      next_ff   <= next_in;
      kraft_ff  <= kraft_in;
      k_ff      <= k_in;
      bad_ff    <= bad_in;
   end

endmodule

/* rtl/canonical_huffman_code_builder_unit.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_code_builder_unit
// canonical huffman code builder: length load, code build and code read
// ----------------------------------------------------------------------------
// Loads, reads and unused opcodes are taken one per cycle whenever busy is
// low, and each gives its result on the rsp_ ports through the first stage
// and the result stage, one cycle long with rsp_strobe; the receiver cannot
// stall, so results are never held back. A build holds busy while the single
// read port of the length memory is walked twice, once to histogram the
// lengths and once to assign the codes, with a kraft and first-code pass
// between; its result is strobed in the first cycle with busy low. After
// reset busy stays high while the length memory is swept to zero.
`include "assert_macros.svh"

module canonical_huffman_code_builder_unit import chcb_pkg::*; #(
   parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
   parameter int MAX_LEN     = MAX_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic [LEN_W-1:0]    req_code_len,
   output logic                rsp_strobe,
   output logic [CODE_W-1:0]   rsp_code_word,
   output logic [LEN_W-1:0]    rsp_code_length,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(NUM_SYMBOLS);

   bld_ctrl_type      bld_ctrl;
   logic [AW-1:0]     bld_len_addr;
   logic [AW-1:0]     bld_code_addr;
   logic [CODE_W-1:0] bld_code_data;

   logic              accept;
   op_type            op;
   logic              in_range;
   logic [AW-1:0]     sym_addr;
   status_type        cur_status;

   logic              len_we, len_re, code_re;
   logic [AW-1:0]     len_waddr, len_raddr;
   logic [LEN_W-1:0]  len_wdata, len_rdata;
   logic [CODE_W-1:0] code_rdata;

   logic              built_ff, built_in;
   logic              err_ff, err_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_read_ff, s1_read_in;
   logic              s1_in_range_ff, s1_in_range_in;
   logic              s1_word_ok_ff, s1_word_ok_in;
   logic [LEN_W-1:0]  s1_len_ff, s1_len_in;
   status_type        s1_status_ff, s1_status_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [CODE_W-1:0] rsp_word_ff, rsp_word_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   status_type        rsp_status_ff, rsp_status_in;

   assign busy     = bld_ctrl.busy;
   assign accept   = start & ~busy;
   assign op       = op_type'(req_opcode);
   assign in_range = 32'(req_symbol) < NUM_SYMBOLS;
   assign sym_addr = AW'(req_symbol);

   always_comb begin
      if (!built_ff) begin
         cur_status = ST_NOT_BUILT;
      end else if (err_ff) begin
         cur_status = ST_BAD;
      end else begin
         cur_status = ST_OK;
      end
   end

   chcb_builder #(
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .MAX_LEN     (MAX_LEN)
   ) u_builder (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && (op == OP_BUILD)),
      .ctrl         (bld_ctrl),
      .len_addr     (bld_len_addr),
      .len_rdata    (len_rdata),
      .code_wr_addr (bld_code_addr),
      .code_wr_data (bld_code_data)
   );

   // length memory: clear sweep and loads write, build walk and reads read
   assign len_we    = bld_ctrl.len_wr | (accept && (op == OP_LOAD) && in_range);
   assign len_waddr = bld_ctrl.len_wr ? bld_len_addr : sym_addr;
   assign len_wdata = bld_ctrl.len_wr ? '0 : req_code_len;
   assign len_re    = bld_ctrl.len_rd | (accept && (op == OP_READ));
   assign len_raddr = busy ? bld_len_addr : sym_addr;
   assign code_re   = accept && (op == OP_READ);

   chcb_ram #(
      .WIDTH (LEN_W),
      .DEPTH (NUM_SYMBOLS)
   ) u_len_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (len_waddr),
      .wdata (len_wdata),
      .re    (len_re),
      .raddr (len_raddr),
      .rdata (len_rdata)
   );

   chcb_ram #(
      .WIDTH (CODE_W),
      .DEPTH (NUM_SYMBOLS)
   ) u_code_ram (
      .clock (clock),
      .we    (bld_ctrl.code_wr),
      .waddr (bld_code_addr),
      .wdata (bld_code_data),
      .re    (code_re),
      .raddr (sym_addr),
      .rdata (code_rdata)
   );

   always_comb begin
      built_in = built_ff;
      err_in   = err_ff;
      if (bld_ctrl.done) begin
         built_in = 1'b1;
         err_in   = bld_ctrl.bad;
      end else if (accept && (op == OP_LOAD)) begin
         built_in = 1'b0;
      end
   end

   // first stage: capture the transfer while the memories are read
   always_comb begin
      s1_valid_in    = 1'b0;
      s1_read_in     = 1'b0;
      s1_in_range_in = in_range;
      s1_word_ok_in  = built_ff & ~err_ff;
      s1_len_in      = '0;
      s1_status_in   = cur_status;
      if (accept) begin
         case (op)
            OP_LOAD: begin
               s1_valid_in  = 1'b1;
               s1_len_in    = in_range ? req_code_len : '0;
               s1_status_in = ST_NOT_BUILT;
            end
            OP_BUILD: begin
               s1_valid_in = 1'b0;
            end
            OP_READ: begin
               s1_valid_in = 1'b1;
               s1_read_in  = 1'b1;
            end
            default: begin
               s1_valid_in = 1'b1;
            end
         endcase
      end
   end

   // result stage: build result or the captured transfer
   always_comb begin
      rsp_strobe_in = s1_valid_ff | bld_ctrl.done;
      rsp_word_in   = '0;
      rsp_len_in    = s1_len_ff;
      rsp_status_in = s1_status_ff;
      if (bld_ctrl.done) begin
         rsp_len_in    = '0;
         rsp_status_in = bld_ctrl.bad ? ST_BAD : ST_OK;
      end else if (s1_read_ff) begin
         rsp_len_in = s1_in_range_ff ? len_rdata : '0;
         if (s1_in_range_ff && s1_word_ok_ff) begin
            rsp_word_in = code_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff      <= 1'b0;
         err_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         built_ff      <= built_in;
         err_ff        <= err_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff     <= s1_read_in;
      s1_in_range_ff <= s1_in_range_in;
      s1_word_ok_ff  <= s1_word_ok_in;
      s1_len_ff      <= s1_len_in;
      s1_status_ff   <= s1_status_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_code_word   = rsp_word_ff;
   assign rsp_code_length = rsp_len_ff;
   assign rsp_status      = rsp_status_ff;

   `CHCB_ASSERT_NEXT(a_build_result, clock, reset, bld_ctrl.done, rsp_strobe && (rsp_status != ST_NOT_BUILT))
   `CHCB_ASSERT_NEXT(a_load_drops_built, clock, reset, accept && (req_opcode == OP_LOAD), !built_ff)
   `CHCB_ASSERT_IMPL(a_code_write_in_build, clock, reset, bld_ctrl.code_wr, bld_ctrl.busy && !accept)
   `CHCB_ASSERT_IMPL(a_single_result_source, clock, reset, bld_ctrl.done, !s1_valid_ff)

endmodule

/* sim/tb_canonical_huffman_code_builder_unit.sv */
// ----------------------------------------------------------------------------
// tb_canonical_huffman_code_builder_unit
// self-checking bench for the canonical huffman code builder: drives length
// loads, builds and reads over the start/busy port, predicts every response
// and compares each strobed response field by field, in order
// ----------------------------------------------------------------------------
module tb_canonical_huffman_code_builder_unit;
   import chcb_pkg::*;

   localparam int NUM_SYM      = NUM_SYMBOLS_DEF;
   localparam int MAX_CODE_LEN = MAX_LEN_DEF;
   localparam int SYM_SPAN     = 1 << SYM_W;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int ITEM_TARGET  = 1200;
   localparam int STALL_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 8;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [CODE_W-1:0]   word;
      logic [LEN_W-1:0]    len;
      logic [STATUS_W-1:0] status;
   } code_rsp_type;

   // tracks the length and code memories and the queue of responses owed
   class huffman_code_tracker;
      logic [LEN_W-1:0]  len_mem  [NUM_SYM];
      logic [CODE_W-1:0] code_mem [NUM_SYM];
      bit                built;
      bit                failed;
      code_rsp_type      pending_codes [$];
      int                errors;

      function new();
         foreach (len_mem[i]) begin
            len_mem[i]  = '0;
            code_mem[i] = '0;
         end
         built  = 0;
         failed = 0;
         errors = 0;
      endfunction

      function status_type cur_status();
         if (!built) return ST_NOT_BUILT;
         return failed ? ST_BAD : ST_OK;
      endfunction

      function void build_codes();
         int counts    [HIST_DEPTH];
         int next_code [HIST_DEPTH];
         int kraft;
         int ln;
         bit bad;
         foreach (counts[i]) counts[i] = 0;
         kraft = 0;
         bad   = 0;
         for (int s = 0; s < NUM_SYM; s++) begin
            ln = len_mem[s];
            counts[ln]++;
            if (ln > MAX_CODE_LEN) bad = 1;
         end
         counts[0] = 0;
         // kraft sum scaled so that a complete code sums to one full word
         for (int l = 1; l < HIST_DEPTH; l++) kraft += counts[l] << (CODE_W - l);
         if (kraft != (1 << CODE_W)) bad = 1;
         next_code[0] = 0;
         next_code[1] = 0;
         for (int l = 2; l < HIST_DEPTH; l++)
            next_code[l] = ((next_code[l-1] + counts[l-1]) << 1) & 32'hFFFFF;
         for (int s = 0; s < NUM_SYM; s++) begin
            ln = len_mem[s];
            if (bad || ln == 0) begin
               code_mem[s] = '0;
            end else begin
               code_mem[s] = CODE_W'(next_code[ln]);
               next_code[ln]++;
            end
         end
         failed = bad;
         built  = 1;
      endfunction

      function void note_command(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                 logic [LEN_W-1:0] ln);
         code_rsp_type rsp;
         bit           in_range;
         in_range = sym < NUM_SYM;
         rsp.word = '0;
         rsp.len  = '0;
         case (op)
            OP_LOAD: begin
               if (in_range) begin
                  len_mem[sym] = ln;
                  rsp.len      = ln;
               end
               built = 0;
            end
            OP_BUILD: build_codes();
            OP_READ: begin
               if (in_range) begin
                  rsp.len = len_mem[sym];
                  if (built && !failed) rsp.word = code_mem[sym];
               end
            end
            default: ;
         endcase
         rsp.status = cur_status();
         pending_codes = {pending_codes, rsp};
      endfunction

      task report_mismatch(string what, int got, int want);
         if (errors < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
         errors++;
      endtask

      task check_response(logic [CODE_W-1:0] word, logic [LEN_W-1:0] len,
                          logic [STATUS_W-1:0] status);
         code_rsp_type want;
         if (pending_codes.size() == 0) begin
            report_mismatch("unexpected response, code_word", word, 0);
            return;
         end
         want = pending_codes.pop_front();
         if (word !== want.word) report_mismatch("code_word", word, want.word);
         if (len !== want.len) report_mismatch("code_length", len, want.len);
         if (status !== want.status) report_mismatch("status", status, want.status);
      endtask

      function int pending();
         return pending_codes.size();
      endfunction
   endclass

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_opcode   = '0;
   logic [SYM_W-1:0]    req_symbol   = '0;
   logic [LEN_W-1:0]    req_code_len = '0;
   logic                rsp_strobe;
   logic [CODE_W-1:0]   rsp_code_word;
   logic [LEN_W-1:0]    rsp_code_length;
   logic [STATUS_W-1:0] rsp_status;

   huffman_code_tracker tracker = new();
   int                  stall_cycles = 0;
   int                  items_sent = 0;
   bit                  no_gaps = 0;
   logic [LEN_W-1:0]    shadow_len [NUM_SYM];
   int                  set_syms [$];
   int                  set_lens [$];

   canonical_huffman_code_builder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_symbol      (req_symbol),
      .req_code_len    (req_code_len),
      .rsp_strobe      (rsp_strobe),
      .rsp_code_word   (rsp_code_word),
      .rsp_code_length (rsp_code_length),
      .rsp_status      (rsp_status)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_strobe) tracker.check_response(rsp_code_word, rsp_code_length, rsp_status);
         if (start && !busy) tracker.note_command(req_opcode, req_symbol, req_code_len);
         if (rsp_strobe || (start && !busy)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                            logic [LEN_W-1:0] ln);
      int gap;
      @(negedge clock);
      start        <= 1'b1;
      req_opcode   <= op;
      req_symbol   <= sym;
      req_code_len <= ln;
      do @(posedge clock); while (busy);
      items_sent++;
      if (op == OP_LOAD && sym < NUM_SYM) shadow_len[sym] = ln;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold off the next transfer until every response is in
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // grow a complete length set by splitting leaves; deep splits form a chain
   function automatic void make_lengths(int n, bit deep);
      int idx;
      set_lens = {1, 1};
      while (set_lens.size() < n) begin
         if (deep) begin
            idx = 0;
            foreach (set_lens[i]) if (set_lens[i] >= set_lens[idx]) idx = i;
         end else begin
            idx = $urandom_range(0, set_lens.size() - 1);
         end
         if (set_lens[idx] < MAX_CODE_LEN) begin
            set_lens[idx]++;
            set_lens = {set_lens, set_lens[idx]};
         end
      end
   endfunction

   function automatic void pick_symbols(int n);
      bit taken [NUM_SYM];
      int s;
      foreach (taken[i]) taken[i] = 0;
      set_syms.delete();
      while (set_syms.size() < n) begin
         s = $urandom_range(0, NUM_SYM - 1);
         if (!taken[s]) begin
            taken[s] = 1;
            set_syms = {set_syms, s};
         end
      end
   endfunction

   // zero every stale length, then load the new set
   task automatic load_set();
      bit member [NUM_SYM];
      foreach (member[i]) member[i] = 0;
      foreach (set_syms[i]) member[set_syms[i]] = 1;
      for (int s = 0; s < NUM_SYM; s++)
         if (shadow_len[s] != 0 && !member[s]) send_item(OP_LOAD, SYM_W'(s), '0);
      foreach (set_syms[i]) send_item(OP_LOAD, SYM_W'(set_syms[i]), LEN_W'(set_lens[i]));
   endtask

   task automatic run_code_set(bit broken, bit deep);
      int n;
      int k;
      int extra;
      int r;
      int s;
      if (deep) n = 16;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(17, 48);
      else n = $urandom_range(2, 12);
      make_lengths(n, deep);
      pick_symbols(n + 1);
      extra = set_syms.pop_back();
      if (broken) begin
         k = $urandom_range(0, n - 1);
         case ($urandom_range(0, 2))
            0: begin
               if (set_lens[k] > 1) set_lens[k]--;
               else set_lens[k]++;
            end
            1: begin
               // incomplete: one leaf missing
               set_syms.delete(k);
               set_lens.delete(k);
            end
            default: begin
               // oversubscribed: one leaf too many
               set_syms = {set_syms, extra};
               set_lens = {set_lens, int'($urandom_range(1, MAX_CODE_LEN))};
            end
         endcase
      end
      load_set();
      send_item(OP_BUILD, SYM_W'($urandom), LEN_W'($urandom));
      repeat (set_syms.size() + $urandom_range(0, 8)) begin
         r = $urandom_range(0, 19);
         if (r < 15) s = set_syms[$urandom_range(0, set_syms.size() - 1)];
         else if (r < 19) s = $urandom_range(0, NUM_SYM - 1);
         else s = $urandom_range(NUM_SYM, SYM_SPAN - 1);
         send_item(OP_READ, SYM_W'(s), LEN_W'($urandom));
      end
   endtask

   task automatic send_noise(int count);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 15);
         if (r < 6)
            send_item(OP_LOAD, SYM_W'($urandom_range(0, SYM_SPAN - 1)), LEN_W'($urandom));
         else if (r < 12)
            send_item(OP_READ, SYM_W'($urandom_range(0, SYM_SPAN - 1)), LEN_W'($urandom));
         else if (r < 14)
            send_item(OP_SPARE, SYM_W'($urandom), LEN_W'($urandom));
         else
            send_item(OP_BUILD, SYM_W'($urandom), LEN_W'($urandom));
      end
   endtask

   initial begin
      int r;
      foreach (shadow_len[i]) shadow_len[i] = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed part
      send_item(OP_READ, '0, '0);                  // nothing built yet
      send_item(OP_SPARE, '1, '1);
      send_item(OP_BUILD, '0, '0);                 // empty set
      send_item(OP_READ, '0, '0);
      send_item(OP_LOAD, 9'd5, 4'd1);
      send_item(OP_READ, 9'd5, '0);                // loaded but not built
      send_item(OP_BUILD, '0, '0);                 // single code
      send_item(OP_READ, 9'd5, '0);
      send_item(OP_LOAD, SYM_W'(NUM_SYM - 1), 4'd1);
      send_item(OP_BUILD, '0, '1);                 // complete pair
      send_item(OP_READ, 9'd5, '0);
      send_item(OP_READ, SYM_W'(NUM_SYM - 1), '0);
      send_item(OP_LOAD, SYM_W'(NUM_SYM), '1);     // out of range still clears built
      send_item(OP_READ, SYM_W'(NUM_SYM), '0);
      send_item(OP_BUILD, '1, '0);
      send_item(OP_READ, '1, '0);
      send_item(OP_READ, '0, '0);                  // unused symbol
      send_item(OP_SPARE, '0, '0);
      send_item(OP_LOAD, '0, 4'd1);                // oversubscribed
      send_item(OP_BUILD, '0, '0);
      send_item(OP_READ, '0, '0);
      send_item(OP_READ, 9'd5, '0);
      drain();

      // one chain down to the longest code, then mixed traffic
      run_code_set(0, 1);
      while (items_sent < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 9);
         if (r < 6) run_code_set(0, ($urandom_range(0, 11) == 0));
         else if (r < 8) run_code_set(1, 0);
         else send_noise($urandom_range(5, 20));
         if ($urandom_range(0, 4) == 0) drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
